// File: sv/assert_macros.svh
// assertion macros shared by the alarm table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define WAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define WAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/wat_pkg.sv
// types and constants of the weekly alarm table
`timescale 1ns / 1ps
package wat_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ADD    = 3'd1,
    OP_UPDATE = 3'd2,
    OP_ENABLE = 3'd3,
    OP_DELETE = 3'd4,
    OP_SNOOZE = 3'd5,
    OP_STOP   = 3'd6,
    OP_READ   = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RD_WAIT,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] days;
    logic       en;
  } entry_t;

  localparam int EntryW = $bits(entry_t);
  localparam int MinuteW = 35;

  localparam logic [0:0] REG_SNOOZE = 1'd0;
  localparam logic [0:0] REG_TONE   = 1'd1;

  localparam logic [1:0] TONE_NONE = 2'd0;
  localparam logic [1:0] TONE_LOW  = 2'd1;
  localparam logic [1:0] TONE_HIGH = 2'd2;

  localparam logic [39:0] VALID_EPOCH = 40'd1700000000;
  localparam logic [6:0]  ALL_DAYS = 7'h7F;
  localparam logic [3:0]  NO_SOURCE = 4'd8;
  localparam logic [MinuteW-1:0] NEVER_MINUTE = '1;
  localparam logic [4:0]  MAX_HOUR = 5'd23;
  localparam logic [5:0]  MAX_MINUTE = 6'd59;
  localparam logic [2:0]  MAX_WEEKDAY = 3'd6;
  localparam logic [11:0] SNOOZE_RESET = 12'd300;
  localparam logic [15:0] TONE_RESET = 16'd700;

endpackage

// File: sv/weekly_alarm_table_with_snooze_core.sv
// Weekly alarm table with snooze. One command at a time: start is taken while busy is low,
// and busy stays high through the cycle of the result strobe done_o, which is high for
// exactly one cycle and cannot be stalled. After the execute state, add, snooze, stop and
// ticks that do not scan go straight to the result state; read, update and set enable
// first wait on one memory read; delete alternates a read and a write state per entry moved
// down. A tick that scans the table first converts epoch seconds to minutes in the divider
// (ten 4-bit steps), then checks the entries in the entry memory one by one, a read state
// and a check state each, until the first match or the last entry. The next beat can be
// taken in the cycle after the result. No clearing pass follows reset; the trigger marks
// use per-slot valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module weekly_alarm_table_with_snooze_core #(
  parameter int ALARM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [2:0]  op_i,
  input  logic [2:0]  slot_i,
  input  logic [4:0]  hour_in_i,
  input  logic [5:0]  minute_in_i,
  input  logic [6:0]  day_mask_in_i,
  input  logic        enable_in_i,
  input  logic [39:0] epoch_seconds_i,
  input  logic [4:0]  local_hour_i,
  input  logic [5:0]  local_minute_i,
  input  logic [2:0]  local_weekday_i,
  input  logic        local_valid_i,
  input  logic [31:0] now_ms_i,
  output logic        done_o,
  output logic        ok_o,
  output logic        ringing_o,
  output logic        ring_start_o,
  output logic        ring_is_snooze_o,
  output logic [3:0]  ring_source_o,
  output logic [1:0]  tone_o,
  output logic [3:0]  alarm_count_o,
  output logic [4:0]  entry_hour_o,
  output logic [5:0]  entry_minute_o,
  output logic [6:0]  entry_days_o,
  output logic        entry_enabled_o,
  output logic [7:0]  snooze_count_o
);
  localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int CW = $clog2(ALARM_SLOTS + 1);
  localparam int MW = wat_pkg::MinuteW;
  localparam int EW = wat_pkg::EntryW;

  wat_pkg::state_e state_q, state_d;

  // latched command beat
  wat_pkg::op_e op_q;
  logic [2:0]  slot_q;
  logic [4:0]  hr_q;
  logic [5:0]  mn_q;
  logic [6:0]  days_q;
  logic        en_in_q;
  logic [39:0] epoch_q;
  logic [4:0]  lh_q;
  logic [5:0]  lm_q;
  logic [2:0]  lw_q;
  logic        lv_q;
  logic [31:0] now_q;

  logic [11:0] snz_sec_q, snz_sec_d;
  logic [15:0] tone_int_q, tone_int_d;
  logic [CW-1:0] total_q, total_d;
  logic        ring_q, ring_d;
  logic        snz_wait_q, snz_wait_d;
  logic [40:0] snz_due_q, snz_due_d;
  logic [7:0]  tally_q, tally_d;
  logic [31:0] last_beep_q, last_beep_d;
  logic        phase_q, phase_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [ALARM_SLOTS-1:0] fvld_q, fvld_d;

  logic        ok_q, ok_d;
  logic        rstart_q, rstart_d;
  logic        is_snz_q, is_snz_d;
  logic [3:0]  src_q, src_d;
  logic [1:0]  tone_q, tone_d;
  wat_pkg::entry_t rd_q, rd_d;

  logic            accept;
  logic            ent_we, fir_we;
  logic [AW-1:0]   ent_waddr, raddr;
  wat_pkg::entry_t ent_wdata, ent_rdata;
  logic [EW-1:0]   ent_rbits;
  logic [MW-1:0]   fir_rdata, fired_cur, cur_min;
  logic            div_start, div_done;

  logic          time_ok, snz_hit, hm_ok, slot_ok, can_add, beep_due;
  logic          scan_go, scan_more, del_more, match;
  logic [CW:0]   idx_inc;
  logic [AW-1:0] slot_a, idx_a;
  logic [6:0]    days_eff, day_sh;

  assign accept = start && !busy;
  assign busy = (state_q != wat_pkg::ST_IDLE);

  wat_ram #(.Width(EW), .Depth(ALARM_SLOTS)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (raddr),
    .rdata_o (ent_rbits)
  );
  assign ent_rdata = wat_pkg::entry_t'(ent_rbits);

  // trigger marks stay with their slot
  wat_ram #(.Width(MW), .Depth(ALARM_SLOTS)) u_fired_ram (
    .clk_i   (clk_i),
    .we_i    (fir_we),
    .waddr_i (idx_a),
    .wdata_i (cur_min),
    .raddr_i (raddr),
    .rdata_o (fir_rdata)
  );

  wat_min_div u_min_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (epoch_q),
    .quotient_o (cur_min),
    .done_o     (div_done)
  );

  assign slot_a   = AW'(slot_q);
  assign idx_a    = idx_q[AW-1:0];
  assign idx_inc  = (CW + 1)'(idx_q) + (CW + 1)'(1);
  assign time_ok  = epoch_q > wat_pkg::VALID_EPOCH;
  assign snz_hit  = snz_wait_q && ({1'b0, epoch_q} >= snz_due_q);
  assign hm_ok    = (hr_q <= wat_pkg::MAX_HOUR) && (mn_q <= wat_pkg::MAX_MINUTE);
  assign slot_ok  = (CW + 3)'(slot_q) < (CW + 3)'(total_q);
  assign can_add  = hm_ok && (total_q < CW'(ALARM_SLOTS));
  assign beep_due = (now_q - last_beep_q) >= {16'd0, tone_int_q};
  assign scan_go  = !ring_q && time_ok && !snz_hit && lv_q && (total_q != '0);
  assign scan_more = idx_inc < (CW + 1)'(total_q);
  assign del_more  = scan_more;
  assign days_eff  = (days_q != '0) ? days_q : wat_pkg::ALL_DAYS;
  assign fired_cur = fvld_q[idx_a] ? fir_rdata : wat_pkg::NEVER_MINUTE;
  assign day_sh    = ent_rdata.days >> lw_q;
  assign match = ent_rdata.en && (ent_rdata.hour == lh_q) && (ent_rdata.minute == lm_q)
              && (fired_cur != cur_min) && (lw_q <= wat_pkg::MAX_WEEKDAY) && day_sh[0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wat_pkg::ST_IDLE: begin
        if (accept) state_d = wat_pkg::ST_EXEC;
      end
      wat_pkg::ST_EXEC: begin
        unique case (op_q)
          wat_pkg::OP_TICK:   state_d = scan_go ? wat_pkg::ST_DIV : wat_pkg::ST_RESP;
          wat_pkg::OP_UPDATE: state_d = (slot_ok && hm_ok) ? wat_pkg::ST_RD_WAIT
                                                           : wat_pkg::ST_RESP;
          wat_pkg::OP_ENABLE,
          wat_pkg::OP_READ:   state_d = slot_ok ? wat_pkg::ST_RD_WAIT : wat_pkg::ST_RESP;
          wat_pkg::OP_DELETE: state_d = slot_ok ? wat_pkg::ST_DEL_RD : wat_pkg::ST_RESP;
          wat_pkg::OP_ADD,
          wat_pkg::OP_SNOOZE,
          wat_pkg::OP_STOP:   state_d = wat_pkg::ST_RESP;
        endcase
      end
      wat_pkg::ST_DIV: begin
        if (div_done) state_d = wat_pkg::ST_SCAN_RD;
      end
      wat_pkg::ST_SCAN_RD:  state_d = wat_pkg::ST_SCAN_CHK;
      wat_pkg::ST_SCAN_CHK: begin
        state_d = (!match && scan_more) ? wat_pkg::ST_SCAN_RD : wat_pkg::ST_RESP;
      end
      wat_pkg::ST_RD_WAIT:  state_d = wat_pkg::ST_RESP;
      wat_pkg::ST_DEL_RD:   state_d = del_more ? wat_pkg::ST_DEL_WR : wat_pkg::ST_RESP;
      wat_pkg::ST_DEL_WR:   state_d = wat_pkg::ST_DEL_RD;
      wat_pkg::ST_RESP:     state_d = wat_pkg::ST_IDLE;
      default:              state_d = wat_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    snz_sec_d   = snz_sec_q;
    tone_int_d  = tone_int_q;
    total_d     = total_q;
    ring_d      = ring_q;
    snz_wait_d  = snz_wait_q;
    snz_due_d   = snz_due_q;
    tally_d     = tally_q;
    last_beep_d = last_beep_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    fvld_d      = fvld_q;
    ok_d        = ok_q;
    rstart_d    = rstart_q;
    is_snz_d    = is_snz_q;
    src_d       = src_q;
    tone_d      = tone_q;
    rd_d        = rd_q;
    ent_we      = 1'b0;
    ent_waddr   = slot_a;
    ent_wdata   = '{hour: hr_q, minute: mn_q, days: days_eff, en: 1'b1};
    fir_we      = 1'b0;
    raddr       = slot_a;
    div_start   = 1'b0;

    if (cfg_we_i) begin
      if (cfg_idx_i == wat_pkg::REG_SNOOZE) snz_sec_d = cfg_wdata_i[11:0];
      if (cfg_idx_i == wat_pkg::REG_TONE)   tone_int_d = cfg_wdata_i;
    end

    unique case (state_q)
      wat_pkg::ST_EXEC: begin
        ok_d     = 1'b0;
        rstart_d = 1'b0;
        is_snz_d = 1'b0;
        src_d    = wat_pkg::NO_SOURCE;
        tone_d   = wat_pkg::TONE_NONE;
        rd_d     = '0;
        idx_d    = '0;
        unique case (op_q)
          wat_pkg::OP_TICK: begin
            ok_d = 1'b1;
            if (ring_q) begin
              if (beep_due) begin
                last_beep_d = now_q;
                tone_d  = phase_q ? wat_pkg::TONE_HIGH : wat_pkg::TONE_LOW;
                phase_d = !phase_q;
              end
            end else if (time_ok && snz_hit) begin
              snz_wait_d  = 1'b0;
              ring_d      = 1'b1;
              last_beep_d = '0;
              phase_d     = 1'b0;
              rstart_d    = 1'b1;
              is_snz_d    = 1'b1;
            end else if (scan_go) begin
              div_start = 1'b1;
            end
          end
          wat_pkg::OP_ADD: begin
            if (can_add) begin
              ent_we    = 1'b1;
              ent_waddr = AW'(total_q);
              total_d   = total_q + CW'(1);
              ok_d      = 1'b1;
            end
          end
          wat_pkg::OP_DELETE: idx_d = CW'(slot_q);
          wat_pkg::OP_SNOOZE: begin
            if (ring_q && time_ok) begin
              tally_d    = tally_q + 8'd1;
              snz_due_d  = {1'b0, epoch_q} + 41'(snz_sec_q);
              snz_wait_d = 1'b1;
              ring_d     = 1'b0;
              ok_d       = 1'b1;
            end
          end
          wat_pkg::OP_STOP: begin
            if (ring_q) begin
              ring_d     = 1'b0;
              snz_wait_d = 1'b0;
              snz_due_d  = '0;
              tally_d    = '0;
              ok_d       = 1'b1;
            end
          end
          wat_pkg::OP_UPDATE,
          wat_pkg::OP_ENABLE,
          wat_pkg::OP_READ: ;
        endcase
      end
      wat_pkg::ST_SCAN_RD: raddr = idx_a;
      wat_pkg::ST_SCAN_CHK: begin
        raddr = idx_a;
        if (match) begin
          fir_we      = 1'b1;
          fvld_d[idx_a] = 1'b1;
          ring_d      = 1'b1;
          last_beep_d = '0;
          phase_d     = 1'b0;
          tally_d     = '0;
          rstart_d    = 1'b1;
          src_d       = 4'(idx_q);
        end else begin
          idx_d = idx_inc[CW-1:0];
        end
      end
      wat_pkg::ST_RD_WAIT: begin
        ok_d = 1'b1;
        if (op_q == wat_pkg::OP_READ) begin
          rd_d = ent_rdata;
        end else if (op_q == wat_pkg::OP_UPDATE) begin
          ent_we    = 1'b1;
          ent_wdata = '{hour: hr_q, minute: mn_q, days: days_eff, en: ent_rdata.en};
        end else begin
          ent_we    = 1'b1;
          ent_wdata = '{hour: ent_rdata.hour, minute: ent_rdata.minute,
                        days: ent_rdata.days, en: en_in_q};
        end
      end
      wat_pkg::ST_DEL_RD: begin
        if (del_more) begin
          raddr = AW'(idx_inc);
        end else begin
          total_d = total_q - CW'(1);
          ok_d    = 1'b1;
        end
      end
      wat_pkg::ST_DEL_WR: begin
        // move the next entry down one place
        ent_we    = 1'b1;
        ent_waddr = idx_a;
        ent_wdata = ent_rdata;
        idx_d     = idx_inc[CW-1:0];
      end
      wat_pkg::ST_IDLE,
      wat_pkg::ST_DIV,
      wat_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wat_pkg::ST_IDLE;
      snz_sec_q   <= wat_pkg::SNOOZE_RESET;
      tone_int_q  <= wat_pkg::TONE_RESET;
      total_q     <= '0;
      ring_q      <= 1'b0;
      snz_wait_q  <= 1'b0;
      snz_due_q   <= '0;
      tally_q     <= '0;
      last_beep_q <= '0;
      phase_q     <= 1'b0;
      idx_q       <= '0;
      fvld_q      <= '0;
    end else begin
      state_q     <= state_d;
      snz_sec_q   <= snz_sec_d;
      tone_int_q  <= tone_int_d;
      total_q     <= total_d;
      ring_q      <= ring_d;
      snz_wait_q  <= snz_wait_d;
      snz_due_q   <= snz_due_d;
      tally_q     <= tally_d;
      last_beep_q <= last_beep_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      fvld_q      <= fvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= wat_pkg::op_e'(op_i);
      slot_q  <= slot_i;
      hr_q    <= hour_in_i;
      mn_q    <= minute_in_i;
      days_q  <= day_mask_in_i;
      en_in_q <= enable_in_i;
      epoch_q <= epoch_seconds_i;
      lh_q    <= local_hour_i;
      lm_q    <= local_minute_i;
      lw_q    <= local_weekday_i;
      lv_q    <= local_valid_i;
      now_q   <= now_ms_i;
    end
    ok_q     <= ok_d;
    rstart_q <= rstart_d;
    is_snz_q <= is_snz_d;
    src_q    <= src_d;
    tone_q   <= tone_d;
    rd_q     <= rd_d;
  end

  assign done_o           = (state_q == wat_pkg::ST_RESP);
  assign ok_o             = ok_q;
  assign ringing_o        = ring_q;
  assign ring_start_o     = rstart_q;
  assign ring_is_snooze_o = is_snz_q;
  assign ring_source_o    = src_q;
  assign tone_o           = tone_q;
  assign alarm_count_o    = 4'(total_q);
  assign entry_hour_o     = rd_q.hour;
  assign entry_minute_o   = rd_q.minute;
  assign entry_days_o     = rd_q.days;
  assign entry_enabled_o  = rd_q.en;
  assign snooze_count_o   = tally_q;

  `WAT_ASSERT_NXT(a_accept_busy, accept, busy && !done_o, "accepted beat did not go busy")
  `WAT_ASSERT_NXT(a_done_single, done_o, !done_o && !busy, "result strobe longer than one cycle")
  `WAT_ASSERT_IMP(a_total_range, 1'b1, total_q <= CW'(ALARM_SLOTS), "entry count out of range")
  `WAT_ASSERT_IMP(a_start_rings, done_o && ring_start_o, ringing_o && tone_o == wat_pkg::TONE_NONE,
                  "ring start without ringing or with a beep")
  `WAT_ASSERT_IMP(a_mem_quiet, !busy, !ent_we && !fir_we, "memory written while idle")

endmodule

// File: sv/wat_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module wat_ram #(
  parameter int Width = 19,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [Width-1:0]       wdata_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [Width-1:0]       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/wat_min_div.sv
// epoch seconds to epoch minutes, four quotient bits per cycle
`timescale 1ns / 1ps
module wat_min_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [39:0]                 dividend_i,
  output logic [wat_pkg::MinuteW-1:0] quotient_o,
  output logic                        done_o
);
  localparam int DigitBits = 4;
  localparam int NumSteps = 40 / DigitBits;
  localparam logic [6:0] Divisor = 7'd60;

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [5:0]  rem_q, rem_d;
  logic [39:0] num_q, num_d;
  logic [5:0]  rem_s;
  logic [39:0] num_s;
  logic [6:0]  trial;

  // restoring steps, numerator bits become quotient bits from the bottom
  always_comb begin
    rem_s = rem_q;
    num_s = num_q;
    trial = '0;
    for (int k = 0; k < DigitBits; k++) begin
      trial = {rem_s, num_s[39]};
      num_s = {num_s[38:0], 1'b0};
      if (trial >= Divisor) begin
        rem_s = 6'(trial - Divisor);
        num_s[0] = 1'b1;
      end else begin
        rem_s = trial[5:0];
      end
    end
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      num_d = dividend_i;
    end else if (run_q) begin
      rem_d = rem_s;
      num_d = num_s;
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(NumSteps - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign quotient_o = num_q[wat_pkg::MinuteW-1:0];
  assign done_o = done_q;

endmodule
